FILE: rtl/mspp_pkg.sv
// Shared types, codes and reply tables of the MQTT server packet parser.
// No dependencies; used by every module of the block but mspp_fifo.
package mspp_pkg;

  localparam int unsigned JOB_DEPTH_DEF = 4;
  localparam logic [27:0] MAX_LEN_RST   = 28'd16383;

  // Result kinds
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_TOPIC = 2'd1;
  localparam logic [1:0] KIND_MSG   = 2'd2;
  localparam logic [1:0] KIND_EVT   = 2'd3;

  // Event codes
  localparam logic [3:0] ST_DONE        = 4'd0;
  localparam logic [3:0] ST_DISC        = 4'd1;
  localparam logic [3:0] ST_CLOSED      = 4'd2;
  localparam logic [3:0] ERR_LENGTH     = 4'd3;
  localparam logic [3:0] ERR_TYPE       = 4'd4;
  localparam logic [3:0] ERR_FLAGS      = 4'd5;
  localparam logic [3:0] ERR_PROTO      = 4'd6;
  localparam logic [3:0] ERR_RESERVED   = 4'd7;
  localparam logic [3:0] ERR_CONNFLAGS  = 4'd8;
  localparam logic [3:0] ERR_MALFORMED  = 4'd9;
  localparam logic [3:0] ERR_SUBOPT     = 4'd10;
  localparam logic [3:0] ERR_DUP        = 4'd11;
  localparam logic [3:0] ERR_QOS3       = 4'd12;
  localparam logic [3:0] ERR_QOS2       = 4'd13;
  localparam logic [3:0] ERR_DISCONNECT = 4'd14;

  // Packet types
  localparam logic [3:0] T_CONNECT    = 4'd1;
  localparam logic [3:0] T_PUBLISH    = 4'd3;
  localparam logic [3:0] T_SUBSCRIBE  = 4'd8;
  localparam logic [3:0] T_PINGREQ    = 4'd12;
  localparam logic [3:0] T_DISCONNECT = 4'd14;

  typedef enum logic [2:0] {
    RP_NONE     = 3'd0,
    RP_CONNACK  = 3'd1,
    RP_SUBACK   = 3'd2,
    RP_PUBACK   = 3'd3,
    RP_PINGRESP = 3'd4
  } reply_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] status;
    logic       last;
  } out_t;

  // Work handed from the parser to the result sequencer
  typedef struct packed {
    logic        stream_v;
    logic [1:0]  stream_kind;
    logic [7:0]  stream_data;
    reply_t      reply;
    logic [15:0] pid;
    logic        evt_v;
    logic [3:0]  evt_st;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  function automatic logic [2:0] reply_len(input reply_t r);
    logic [2:0] n;
    unique case (r)
      RP_CONNACK:  n = 3'd4;
      RP_SUBACK:   n = 3'd5;
      RP_PUBACK:   n = 3'd6;
      RP_PINGRESP: n = 3'd2;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] reply_byte(input reply_t r, input logic [2:0] idx,
                                            input logic [15:0] pid);
    logic [7:0] d;
    d = 8'h00;
    unique case (r)
      RP_CONNACK: begin
        if (idx == 3'd0) d = 8'h20;
        else if (idx == 3'd1) d = 8'h02;
      end
      RP_SUBACK: begin
        if (idx == 3'd0) d = 8'h90;
        else if (idx == 3'd1) d = 8'h03;
        else if (idx == 3'd2) d = pid[15:8];
        else if (idx == 3'd3) d = pid[7:0];
      end
      RP_PUBACK: begin
        if (idx == 3'd0) d = 8'h40;
        else if (idx == 3'd1) d = 8'h04;
        else if (idx == 3'd2) d = pid[15:8];
        else if (idx == 3'd3) d = pid[7:0];
      end
      RP_PINGRESP: begin
        if (idx == 3'd0) d = 8'hD0;
      end
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/mspp_fifo.sv
// Small register queue carrying parser jobs to the result sequencer.
// Depends on nothing but its parameters.
module mspp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // Store request data
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end
endmodule

FILE: rtl/mspp_front.sv
// Byte parser: fixed header, body checks and job generation per byte.
// Depends on mspp_pkg.
module mspp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  mspp_pkg::in_t in_item,
  input  logic          cfg_we,
  input  logic [27:0]   cfg_wdata,
  output logic          job_push,
  output mspp_pkg::job_t job
);
  import mspp_pkg::*;

  typedef enum logic [24:0] {
    PH_IDLE     = 25'h0000001,
    PH_LEN      = 25'h0000002,
    PH_C_NLEN   = 25'h0000004,
    PH_C_NAME   = 25'h0000008,
    PH_C_VER    = 25'h0000010,
    PH_C_FLAGS  = 25'h0000020,
    PH_C_KA     = 25'h0000040,
    PH_C_IDLEN  = 25'h0000080,
    PH_C_ID     = 25'h0000100,
    PH_C_WTLEN  = 25'h0000200,
    PH_C_WT     = 25'h0000400,
    PH_C_WMLEN  = 25'h0000800,
    PH_C_WM     = 25'h0001000,
    PH_C_DONE   = 25'h0002000,
    PH_S_ID     = 25'h0004000,
    PH_S_TLEN   = 25'h0008000,
    PH_S_TOPIC  = 25'h0010000,
    PH_S_OPT    = 25'h0020000,
    PH_P_TLEN   = 25'h0040000,
    PH_P_TOPIC  = 25'h0080000,
    PH_P_PID    = 25'h0100000,
    PH_P_MSG    = 25'h0200000,
    PH_SKIP     = 25'h0400000,
    PH_D_REASON = 25'h0800000,
    PH_D_DONE   = 25'h1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pkt_type_r, pkt_type_nxt;
  logic [3:0]  hdr_flags_r, hdr_flags_nxt;
  logic [27:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]  lbi_r, lbi_nxt;
  logic [15:0] field_left_r, field_left_nxt;
  logic        will_r, will_nxt;
  logic [15:0] packet_id_r, packet_id_nxt;
  logic [2:0]  name_pos_r, name_pos_nxt;
  logic        halted_r, halted_nxt;
  logic [27:0] max_len_r;

  logic [7:0]  b;
  logic [15:0] t_val, fl_dec;
  logic        t_done, failed, fin, fin_ok, hdr;
  logic [1:0]  qos;
  logic [27:0] len_add;
  logic [7:0]  name_ch;

  assign b      = in_item.rx_byte;
  assign qos    = hdr_flags_r[2:1];
  assign t_done = lbi_r[0];
  assign t_val  = t_done ? {field_left_r[15:8], b} : {b, 8'h00};
  assign fl_dec = field_left_r - 16'd1;

  // Expected protocol name character
  always_comb begin
    unique case (name_pos_r[1:0])
      2'd0:    name_ch = 8'h4D;
      2'd1:    name_ch = 8'h51;
      default: name_ch = 8'h54;
    endcase
  end

  // Weight the length digit
  always_comb begin
    unique case (lbi_r)
      2'd0:    len_add = {21'd0, b[6:0]};
      2'd1:    len_add = {14'd0, b[6:0], 7'd0};
      2'd2:    len_add = {7'd0, b[6:0], 14'd0};
      default: len_add = {b[6:0], 21'd0};
    endcase
  end

  // Parse one byte and build its job
  always_comb begin
    phase_nxt      = phase_r;
    pkt_type_nxt   = pkt_type_r;
    hdr_flags_nxt  = hdr_flags_r;
    bytes_left_nxt = bytes_left_r;
    lbi_nxt        = lbi_r;
    field_left_nxt = field_left_r;
    will_nxt       = will_r;
    packet_id_nxt  = packet_id_r;
    name_pos_nxt   = name_pos_r;
    halted_nxt     = halted_r;
    job            = '0;
    job.reply      = RP_NONE;
    failed         = 1'b0;
    fin            = 1'b0;
    fin_ok         = 1'b0;
    hdr            = 1'b0;

    if (accept && !halted_r) begin
      if (in_item.cmd) begin
        job.evt_v      = 1'b1;
        job.evt_st     = ST_CLOSED;
        phase_nxt      = PH_IDLE;
        lbi_nxt        = 2'd0;
        bytes_left_nxt = '0;
      end else if (phase_r == PH_IDLE) begin
        pkt_type_nxt   = b[7:4];
        hdr_flags_nxt  = b[3:0];
        bytes_left_nxt = '0;
        lbi_nxt        = 2'd0;
        phase_nxt      = PH_LEN;
      end else if (phase_r == PH_LEN) begin
        bytes_left_nxt = bytes_left_r | len_add;
        if (b[7] && lbi_r != 2'd3) lbi_nxt = lbi_r + 2'd1;
        else hdr = 1'b1;
      end else begin
        if (bytes_left_r != '0) bytes_left_nxt = bytes_left_r - 28'd1;
        unique case (phase_r)
          PH_C_NLEN: begin
            field_left_nxt = t_val;
            lbi_nxt        = t_done ? 2'd0 : 2'd1;
            if (t_done) begin
              if (t_val != 16'd4) begin
                failed = 1'b1; job.evt_st = ERR_PROTO;
              end else begin
                name_pos_nxt = 3'd0; phase_nxt = PH_C_NAME;
              end
            end
          end
          PH_C_NAME: begin
            if (b != name_ch) begin
              failed = 1'b1; job.evt_st = ERR_PROTO;
            end else begin
              name_pos_nxt = name_pos_r + 3'd1;
              if (name_pos_r + 3'd1 >= 3'd4) phase_nxt = PH_C_VER;
            end
          end
          PH_C_VER: phase_nxt = PH_C_FLAGS;
          PH_C_FLAGS: begin
            will_nxt = b[2];
            if (b[0]) begin
              failed = 1'b1; job.evt_st = ERR_RESERVED;
            end else if (b[7:6] != 2'b00) begin
              failed = 1'b1; job.evt_st = ERR_CONNFLAGS;
            end else phase_nxt = PH_C_KA;
          end
          PH_C_KA, PH_C_IDLEN, PH_C_WTLEN, PH_C_WMLEN, PH_S_ID, PH_S_TLEN,
          PH_P_TLEN, PH_P_PID: begin
            field_left_nxt = t_val;
            lbi_nxt        = t_done ? 2'd0 : 2'd1;
            if (t_done) begin
              case (phase_r)
                PH_C_KA:    phase_nxt = PH_C_IDLEN;
                PH_C_IDLEN: phase_nxt = (t_val != '0) ? PH_C_ID :
                                        (will_r ? PH_C_WTLEN : PH_C_DONE);
                PH_C_WTLEN: phase_nxt = (t_val != '0) ? PH_C_WT : PH_C_WMLEN;
                PH_C_WMLEN: phase_nxt = (t_val != '0) ? PH_C_WM : PH_C_DONE;
                PH_S_ID: begin
                  packet_id_nxt = t_val; phase_nxt = PH_S_TLEN;
                end
                PH_S_TLEN:  phase_nxt = (t_val != '0) ? PH_S_TOPIC : PH_S_OPT;
                PH_P_TLEN:  phase_nxt = (t_val != '0) ? PH_P_TOPIC :
                                        ((qos == 2'd1) ? PH_P_PID : PH_P_MSG);
                default: begin
                  packet_id_nxt = t_val; phase_nxt = PH_P_MSG;
                end
              endcase
            end
          end
          PH_C_ID, PH_C_WT, PH_C_WM, PH_S_TOPIC, PH_P_TOPIC: begin
            field_left_nxt = fl_dec;
            if (phase_r == PH_P_TOPIC) begin
              job.stream_v    = 1'b1;
              job.stream_kind = KIND_TOPIC;
              job.stream_data = b;
            end
            if (fl_dec == '0) begin
              case (phase_r)
                PH_C_ID:    phase_nxt = will_r ? PH_C_WTLEN : PH_C_DONE;
                PH_C_WT:    phase_nxt = PH_C_WMLEN;
                PH_C_WM:    phase_nxt = PH_C_DONE;
                PH_S_TOPIC: phase_nxt = PH_S_OPT;
                default:    phase_nxt = (qos == 2'd1) ? PH_P_PID : PH_P_MSG;
              endcase
            end
          end
          PH_C_DONE: begin
            failed = 1'b1; job.evt_st = ERR_MALFORMED;
          end
          PH_S_OPT: begin
            if (b[7:1] != '0) begin
              failed = 1'b1; job.evt_st = ERR_SUBOPT;
            end else phase_nxt = PH_S_TLEN;
          end
          PH_P_MSG: begin
            job.stream_v    = 1'b1;
            job.stream_kind = KIND_MSG;
            job.stream_data = b;
          end
          PH_SKIP: ;
          PH_D_REASON: begin
            if (b != 8'd0) begin
              failed = 1'b1; job.evt_st = ERR_DISCONNECT;
            end else phase_nxt = PH_D_DONE;
          end
          PH_D_DONE: begin
            failed = 1'b1; job.evt_st = ERR_DISCONNECT;
          end
          default: begin
            phase_nxt = PH_IDLE; lbi_nxt = 2'd0;
          end
        endcase
        if (!failed && phase_nxt != PH_IDLE && bytes_left_nxt == '0) fin = 1'b1;
      end

      // Check the completed fixed header
      if (hdr) begin
        lbi_nxt = 2'd0;
        if (bytes_left_nxt > max_len_r) begin
          failed = 1'b1; job.evt_st = ERR_LENGTH;
        end else begin
          case (pkt_type_r)
            T_CONNECT: begin
              if (hdr_flags_r != 4'd0) begin
                failed = 1'b1; job.evt_st = ERR_FLAGS;
              end else phase_nxt = PH_C_NLEN;
            end
            T_SUBSCRIBE: begin
              if (hdr_flags_r != 4'd2) begin
                failed = 1'b1; job.evt_st = ERR_FLAGS;
              end else phase_nxt = PH_S_ID;
            end
            T_PINGREQ: begin
              if (hdr_flags_r != 4'd0) begin
                failed = 1'b1; job.evt_st = ERR_FLAGS;
              end else phase_nxt = PH_SKIP;
            end
            T_PUBLISH: begin
              if (qos == 2'd0 && hdr_flags_r[3]) begin
                failed = 1'b1; job.evt_st = ERR_DUP;
              end else if (qos == 2'd3) begin
                failed = 1'b1; job.evt_st = ERR_QOS3;
              end else if (qos == 2'd2) begin
                failed = 1'b1; job.evt_st = ERR_QOS2;
              end else phase_nxt = PH_P_TLEN;
            end
            T_DISCONNECT: phase_nxt = PH_D_REASON;
            default: begin
              failed = 1'b1; job.evt_st = ERR_TYPE;
            end
          endcase
        end
        if (!failed && bytes_left_nxt == '0) fin = 1'b1;
      end

      // Close the packet: send replies and the end event, or flag it malformed
      if (fin) begin
        case (phase_nxt)
          PH_C_DONE, PH_P_MSG, PH_SKIP, PH_D_REASON, PH_D_DONE: fin_ok = 1'b1;
          PH_S_TLEN: fin_ok = (lbi_nxt == 2'd0);
          default:   fin_ok = 1'b0;
        endcase
        if (!fin_ok) begin
          failed = 1'b1; job.evt_st = ERR_MALFORMED;
        end else begin
          job.evt_v  = 1'b1;
          job.evt_st = ST_DONE;
          job.pid    = packet_id_nxt;
          case (pkt_type_r)
            T_CONNECT:   job.reply = RP_CONNACK;
            T_SUBSCRIBE: job.reply = RP_SUBACK;
            T_PUBLISH:   job.reply = (qos == 2'd1) ? RP_PUBACK : RP_NONE;
            T_PINGREQ:   job.reply = RP_PINGRESP;
            default:     job.evt_st = ST_DISC;
          endcase
          phase_nxt = PH_IDLE;
          lbi_nxt   = 2'd0;
        end
      end

      // Halt on a fatal check
      if (failed) begin
        job.evt_v  = 1'b1;
        halted_nxt = 1'b1;
        phase_nxt  = PH_IDLE;
        lbi_nxt    = 2'd0;
      end
    end
  end

  assign job_push = job.stream_v || job.evt_v;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      pkt_type_r   <= '0;
      hdr_flags_r  <= '0;
      bytes_left_r <= '0;
      lbi_r        <= '0;
      field_left_r <= '0;
      will_r       <= 1'b0;
      packet_id_r  <= '0;
      name_pos_r   <= '0;
      halted_r     <= 1'b0;
      max_len_r    <= MAX_LEN_RST;
    end else begin
      phase_r      <= phase_nxt;
      pkt_type_r   <= pkt_type_nxt;
      hdr_flags_r  <= hdr_flags_nxt;
      bytes_left_r <= bytes_left_nxt;
      lbi_r        <= lbi_nxt;
      field_left_r <= field_left_nxt;
      will_r       <= will_nxt;
      packet_id_r  <= packet_id_nxt;
      name_pos_r   <= name_pos_nxt;
      halted_r     <= halted_nxt;
      if (cfg_we) max_len_r <= cfg_wdata;
    end
  end
endmodule

FILE: rtl/mspp_back.sv
// Result sequencer: expands one job into its result items, one per cycle
// while the receiver keeps up. Depends on mspp_pkg.
module mspp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  mspp_pkg::job_t job,
  input  logic           job_empty,
  output logic           job_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output mspp_pkg::out_t out_item
);
  import mspp_pkg::*;

  logic [2:0] seq_r, rpos, nrep, total;
  logic       out_v_r, gen, is_last;
  out_t       res, out_r;

  assign nrep    = reply_len(job.reply);
  assign total   = 3'(job.stream_v) + nrep + 3'(job.evt_v);
  assign rpos    = seq_r - 3'(job.stream_v);
  assign is_last = (seq_r == total - 3'd1);
  assign gen     = !job_empty && (!out_v_r || out_pop);
  assign job_pop = gen && is_last;

  // Pick the result at the current position
  always_comb begin
    res      = '0;
    res.last = is_last;
    if (job.stream_v && seq_r == 3'd0) begin
      res.kind = job.stream_kind;
      res.data = job.stream_data;
    end else if (rpos < nrep) begin
      res.kind = KIND_REPLY;
      res.data = reply_byte(job.reply, rpos, job.pid);
    end else begin
      res.kind   = KIND_EVT;
      res.status = job.evt_st;
    end
  end

  // Advance through the job and hold the result for the receiver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= '0;
      out_v_r <= 1'b0;
    end else if (gen) begin
      out_v_r <= 1'b1;
      seq_r   <= is_last ? 3'd0 : seq_r + 3'd1;
    end else if (out_pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) out_r <= res;
  end

  assign out_empty = !out_v_r;
  assign out_item  = out_r;
endmodule

FILE: rtl/mqtt_server_packet_parser_unit.sv
// MQTT server packet parser: one client byte or peer close per request.
// Usage:
//   Input queue: drive in_item and in_push; a request is taken at a clock edge
//   where in_push is high and in_full is low, at up to one byte per cycle.
//   Result queue: while out_empty is low the oldest result sits on out_item;
//   out_pop takes it. A request yields zero to eight results; the final one
//   carries last.
//   The parser takes one byte per cycle while in_full is low; the sequencer
//   gives one result per cycle while the receiver keeps up, so a burst of up
//   to eight results drains while the job queue (JOB_DEPTH entries) absorbs
//   further bytes.
//   When the receiver stalls, the job queue fills and in_full rises.
//   cfg_we / cfg_wdata set the largest accepted remaining length; write only
//   while idle.
//   Reset (rst_n low, synchronous) clears the parser to await a header,
//   empties both queues, and restores the limit to 16383. A fatal error
//   event halts the parser until the next reset.
//   Depends on mspp_pkg, mspp_front, mspp_fifo and mspp_back.
module mqtt_server_packet_parser_unit #(
  parameter int unsigned JOB_DEPTH = mspp_pkg::JOB_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  mspp_pkg::in_t  in_item,
  output logic           out_empty,
  input  logic           out_pop,
  output mspp_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic [27:0]    cfg_wdata
);
  import mspp_pkg::*;

  logic accept, job_push, job_full, job_empty, job_pop;
  job_t job_in, job_out;
  logic [JOB_W-1:0] job_rd;

  assign in_full = job_full;
  assign accept  = in_push && !job_full;
  assign job_out = job_t'(job_rd);

  mspp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_push  (job_push),
    .job       (job_in)
  );

  mspp_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rd),
    .empty (job_empty)
  );

  mspp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind != KIND_EVT |-> out_item.status == 4'd0)
    else $error("byte result carries a status");
  a_evt_data: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.kind == KIND_EVT |-> out_item.data == 8'd0)
    else $error("event carries data");
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(job_full && job_empty))
    else $error("job queue both full and empty");
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");
`endif
endmodule
